// File: src/wsu_pkg.sv
// Shared types and constants of the waveform sample unpacker.
`timescale 1ns / 1ps

package wsu_pkg;

   // Sample format codes held in the format register.
   localparam logic [3:0] FMT_DIFF8   = 4'd0;
   localparam logic [3:0] FMT_LE16    = 4'd1;
   localparam logic [3:0] FMT_LE24    = 4'd2;
   localparam logic [3:0] FMT_LE32    = 4'd3;
   localparam logic [3:0] FMT_BE16    = 4'd4;
   localparam logic [3:0] FMT_OFFS8   = 4'd5;
   localparam logic [3:0] FMT_OFFS16  = 4'd6;
   localparam logic [3:0] FMT_PACK212 = 4'd7;
   localparam logic [3:0] FMT_PACK310 = 4'd8;
   localparam logic [3:0] FMT_PACK311 = 4'd9;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS = 2'd1;

   // Reset values of the registers.
   localparam logic [3:0] FORMAT_RESET   = FMT_LE16;
   localparam logic [4:0] CHANNELS_RESET = 5'd1;

   // Result queue between the decoder and the result port.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic [3:0]         channel_index;
      logic               frame_end;
      logic               last_of_run;
   } result_type;

   // Results produced by one decoded byte: none, one or two.
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } decode_out_type;

   typedef struct packed {
      logic                   write_enable;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  write_data;
   } csr_write_type;

endpackage

// File: src/wsu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module wsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_enable,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/wsu_decoder.sv
// Byte decoder: format state, channel sequencing and the format 8 running totals.
`timescale 1ns / 1ps

module wsu_decoder import wsu_pkg::*; #(
   parameter int MAX_CHANNELS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  csr_write_type  csr,
   input  logic           decode_go,
   input  logic [7:0]     data_byte,
   output decode_out_type results
);

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   logic [3:0]  format_ff, format_in;
   logic [4:0]  channels_ff, channels_in;
   logic [1:0]  pos_ff, pos_in;
   logic [23:0] part_ff, part_in;
   logic [15:0] word1_ff, word1_in;
   logic [15:0] word2_ff, word2_in;
   logic [CH_W-1:0] ch_ff, ch_in;

   logic [MAX_CHANNELS-1:0] valid_ff, valid_in;
   logic        valid_rd_ff, valid_rd_in;
   logic        bypass_ff, bypass_in;
   logic [31:0] bypass_val_ff;

   logic [CNT_W-1:0] frame_n;
   logic [CH_W-1:0]  last_ch, ch_next1, ch_next2;
   logic [23:0] part_ins;
   logic [31:0] ram_rd_data, total_base, total_sum;
   logic        ram_we;
   logic [1:0]  nres;
   logic [31:0] val0, val1;
   logic [9:0]  pack10;
   logic [11:0] pack12;
   logic [15:0] word16;
   logic [15:0] new_word;

   // Effective frame size: zero acts as one, large counts are clamped.
   always_comb begin
      if (channels_ff == 5'd0) begin
         frame_n = CNT_W'(1);
      end else if (int'(channels_ff) > MAX_CHANNELS) begin
         frame_n = CNT_W'(MAX_CHANNELS);
      end else begin
         frame_n = CNT_W'(channels_ff);
      end
      last_ch  = CH_W'(frame_n - CNT_W'(1));
      ch_next1 = (ch_ff == last_ch) ? '0 : ch_ff + CH_W'(1);
      ch_next2 = (ch_next1 == last_ch) ? '0 : ch_next1 + CH_W'(1);
   end

   // Current byte dropped into its slot of the partial little-endian word.
   always_comb begin
      part_ins = part_ff;
      case (pos_ff)
         2'd0:    part_ins[7:0]   = data_byte;
         2'd1:    part_ins[15:8]  = data_byte;
         default: part_ins[23:16] = data_byte;
      endcase
   end

   // Format 8: the stored total of this channel, forwarded if just written.
   assign total_base = bypass_ff ? bypass_val_ff : (valid_rd_ff ? ram_rd_data : 32'd0);
   assign total_sum  = total_base + {{24{data_byte[7]}}, data_byte};

   // Per-format decode of one byte and the next state.
   always_comb begin
      format_in   = format_ff;
      channels_in = channels_ff;
      pos_in      = pos_ff;
      part_in     = part_ff;
      word1_in    = word1_ff;
      word2_in    = word2_ff;
      nres        = 2'd0;
      val0        = 32'd0;
      val1        = 32'd0;
      ram_we      = 1'b0;
      pack10      = 10'd0;
      pack12      = 12'd0;
      word16      = 16'd0;
      new_word    = {data_byte, part_ff[7:0]};
      if (decode_go) begin
         case (format_ff)
            FMT_DIFF8: begin
               nres   = 2'd1;
               val0   = total_sum;
               ram_we = 1'b1;
            end
            FMT_LE16, FMT_OFFS16: begin
               if (pos_ff != 2'd0) begin
                  word16  = {data_byte, part_ff[7:0]};
                  if (format_ff == FMT_OFFS16) begin
                     word16[15] = ~word16[15];
                  end
                  val0    = {{16{word16[15]}}, word16};
                  nres    = 2'd1;
                  pos_in  = 2'd0;
                  part_in = 24'd0;
               end else begin
                  part_in = part_ins;
                  pos_in  = pos_ff + 2'd1;
               end
            end
            FMT_LE24: begin
               if (pos_ff >= 2'd2) begin
                  val0    = {{8{data_byte[7]}}, data_byte, part_ff[15:0]};
                  nres    = 2'd1;
                  pos_in  = 2'd0;
                  part_in = 24'd0;
               end else begin
                  part_in = part_ins;
                  pos_in  = pos_ff + 2'd1;
               end
            end
            FMT_LE32: begin
               if (pos_ff == 2'd3) begin
                  val0    = {data_byte, part_ff};
                  nres    = 2'd1;
                  pos_in  = 2'd0;
                  part_in = 24'd0;
               end else begin
                  part_in = part_ins;
                  pos_in  = pos_ff + 2'd1;
               end
            end
            FMT_BE16: begin
               if (pos_ff == 2'd0) begin
                  part_in = {16'd0, data_byte};
                  pos_in  = 2'd1;
               end else begin
                  val0    = {{16{part_ff[7]}}, part_ff[7:0], data_byte};
                  nres    = 2'd1;
                  pos_in  = 2'd0;
                  part_in = 24'd0;
               end
            end
            FMT_OFFS8: begin
               // Subtracting 128 from an unsigned byte flips its top bit.
               val0 = {{24{~data_byte[7]}}, ~data_byte[7], data_byte[6:0]};
               nres = 2'd1;
            end
            FMT_PACK212: begin
               if (pos_ff == 2'd0) begin
                  part_in = {16'd0, data_byte};
                  pos_in  = 2'd1;
               end else if (pos_ff == 2'd1) begin
                  word1_in = new_word;
                  pos_in   = 2'd2;
                  pack12   = new_word[11:0];
                  val0     = {{20{pack12[11]}}, pack12};
                  nres     = 2'd1;
               end else begin
                  pack12  = {word1_ff[15:12], data_byte};
                  val0    = {{20{pack12[11]}}, pack12};
                  nres    = 2'd1;
                  pos_in  = 2'd0;
                  part_in = 24'd0;
               end
            end
            FMT_PACK310: begin
               if (pos_ff == 2'd0 || pos_ff == 2'd2) begin
                  part_in = {16'd0, data_byte};
                  pos_in  = pos_ff + 2'd1;
               end else if (pos_ff == 2'd1) begin
                  word1_in = new_word;
                  pos_in   = 2'd2;
                  pack10   = new_word[10:1];
                  val0     = {{22{pack10[9]}}, pack10};
                  nres     = 2'd1;
               end else begin
                  // Last byte of the group completes two samples.
                  word2_in = new_word;
                  pos_in   = 2'd0;
                  part_in  = 24'd0;
                  pack10   = new_word[10:1];
                  val0     = {{22{pack10[9]}}, pack10};
                  val1     = {{22{new_word[15]}}, new_word[15:11], word1_ff[15:11]};
                  nres     = 2'd2;
               end
            end
            FMT_PACK311: begin
               if (pos_ff == 2'd0) begin
                  part_in = {16'd0, data_byte};
                  pos_in  = 2'd1;
               end else if (pos_ff == 2'd1) begin
                  word1_in = new_word;
                  pos_in   = 2'd2;
                  pack10   = new_word[9:0];
                  val0     = {{22{pack10[9]}}, pack10};
                  nres     = 2'd1;
               end else if (pos_ff == 2'd2) begin
                  word2_in = {8'd0, data_byte};
                  pos_in   = 2'd3;
                  pack10   = {data_byte[3:0], word1_ff[15:10]};
                  val0     = {{22{pack10[9]}}, pack10};
                  nres     = 2'd1;
               end else begin
                  word2_in = {data_byte, word2_ff[7:0]};
                  pos_in   = 2'd0;
                  part_in  = 24'd0;
                  pack10   = {data_byte[5:0], word2_ff[7:4]};
                  val0     = {{22{pack10[9]}}, pack10};
                  nres     = 2'd1;
               end
            end
            default: begin
               nres = 2'd0;
            end
         endcase
      end

      // Channel moves on by the number of samples produced.
      case (nres)
         2'd1:    ch_in = ch_next1;
         2'd2:    ch_in = ch_next2;
         default: ch_in = ch_ff;
      endcase

      // A register write restarts on a word and frame boundary.
      if (csr.write_enable && (csr.index == CSR_FORMAT || csr.index == CSR_CHANNELS)) begin
         if (csr.index == CSR_FORMAT) begin
            format_in = csr.write_data[3:0];
         end else begin
            channels_in = csr.write_data;
         end
         pos_in   = 2'd0;
         part_in  = 24'd0;
         word1_in = 16'd0;
         word2_in = 16'd0;
         ch_in    = '0;
      end
   end

   // Totals storage: valid bits stand in for the cleared reset contents.
   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[ch_ff] = 1'b1;
      end
      valid_rd_in = valid_ff[ch_in];
      bypass_in   = ram_we && (ch_ff == ch_in);
   end

   wsu_ram #(
      .WIDTH (32),
      .DEPTH (MAX_CHANNELS)
   ) u_totals (
      .clock     (clock),
      .wr_enable (ram_we),
      .wr_addr   (ch_ff),
      .wr_data   (total_sum),
      .rd_addr   (ch_in),
      .rd_data   (ram_rd_data)
   );

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff   <= FORMAT_RESET;
         channels_ff <= CHANNELS_RESET;
         pos_ff      <= 2'd0;
         part_ff     <= 24'd0;
         word1_ff    <= 16'd0;
         word2_ff    <= 16'd0;
         ch_ff       <= '0;
         valid_ff    <= '0;
         valid_rd_ff <= 1'b0;
         bypass_ff   <= 1'b0;
      end else begin
         format_ff   <= format_in;
         channels_ff <= channels_in;
         pos_ff      <= pos_in;
         part_ff     <= part_in;
         word1_ff    <= word1_in;
         word2_ff    <= word2_in;
         ch_ff       <= ch_in;
         valid_ff    <= valid_in;
         valid_rd_ff <= valid_rd_in;
         bypass_ff   <= bypass_in;
      end
      bypass_val_ff <= total_sum;
   end

   // Result beats handed to the queue.
   always_comb begin
      results.count                = nres;
      results.first.sample_value   = val0;
      results.first.channel_index  = 4'(ch_ff);
      results.first.frame_end      = (ch_ff == last_ch);
      results.first.last_of_run    = (nres == 2'd1);
      results.second.sample_value  = val1;
      results.second.channel_index = 4'(ch_next1);
      results.second.frame_end     = (ch_next1 == last_ch);
      results.second.last_of_run   = 1'b1;
   end

   // The channel never runs past the last one of the frame.
   a_channel_in_frame: assert property (@(posedge clock) disable iff (reset)
      ch_ff <= last_ch)
      else $error("channel beyond end of frame");

   // Only the packed 310 format yields two samples from one byte.
   a_pair_only_310: assert property (@(posedge clock) disable iff (reset)
      nres == 2'd2 |-> format_ff == FMT_PACK310 && pos_ff == 2'd3)
      else $error("two samples from a byte outside format 310");

endmodule

// File: src/wsu_result_queue.sv
// Short result queue: takes up to two result beats a cycle, delivers one unless out_stall is high.
`timescale 1ns / 1ps

module wsu_result_queue import wsu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  decode_out_type push,
   output logic           room,
   output logic           out_valid,
   input  logic           out_stall,
   output result_type     out_beat
);

   result_type q_ff [QUEUE_DEPTH];
   result_type q_in [QUEUE_DEPTH];
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_CNT_W-1:0] base;
   logic pop;

   assign out_valid = (count_ff != '0);
   assign out_beat  = q_ff[0];
   assign pop       = out_valid && !out_stall;
   // Space for the largest burst one byte can cause.
   assign room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign base      = count_ff - QUEUE_CNT_W'(pop);
   assign count_in  = base + QUEUE_CNT_W'(push.count);

   // Head always sits in entry 0; new beats go behind the last one held.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push.count != 2'd0 && QUEUE_CNT_W'(i) == base) begin
            q_in[i] = push.first;
         end
         if (push.count == 2'd2 && QUEUE_CNT_W'(i) == base + QUEUE_CNT_W'(1)) begin
            q_in[i] = push.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // The queue never overfills.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= QUEUE_DEPTH)
      else $error("result queue overflow");

   // Nothing is pushed unless there was room for a full burst.
   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("result pushed without room");

endmodule

// File: src/waveform_sample_unpacker_unit.sv
// Top level of the waveform sample unpacker: input register, decoder and result queue.
`timescale 1ns / 1ps

// Decodes a signal data file fed one byte per beat into signed samples tagged with
// their channel, frame end and a last-of-run flag on the final sample caused by a byte.
// One byte is taken every cycle unless stalled; it waits in the input register until the
// queue has room, and its samples are registered in the queue before they leave. Most
// bytes give at most one sample, the last byte of a format 310 group gives two, and a
// four-entry result queue absorbs those so the byte rate stays at one per cycle while the
// result side keeps up. The format 8 running totals live in a small RAM with registered
// read, read ahead at the next channel and forwarded when that channel was just written.
// Registers may be written only while no byte or sample is in flight; any write of either
// register restarts packing and the channel sequence at channel 0, keeping the totals.
module waveform_sample_unpacker_unit import wsu_pkg::*; #(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_sample_value,
   output logic [3:0]             rsp_channel_index,
   output logic                   rsp_frame_end,
   output logic                   rsp_last_of_run,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           room;
   logic           decode_go;
   logic           accept;
   csr_write_type  csr;
   decode_out_type results;
   result_type     out_beat;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.write_data   = csr_write_data;

   // Input register: a byte waits here until the queue can hold its samples.
   assign decode_go   = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (decode_go ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff <= req_data_byte;
      end
   end

   wsu_decoder #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .decode_go (decode_go),
      .data_byte (in_byte_ff),
      .results   (results)
   );

   wsu_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_beat  (out_beat)
   );

   assign rsp_sample_value  = out_beat.sample_value;
   assign rsp_channel_index = out_beat.channel_index;
   assign rsp_frame_end     = out_beat.frame_end;
   assign rsp_last_of_run   = out_beat.last_of_run;

   // A stall is raised only while a byte is held waiting for queue space.
   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && !room)
      else $error("input stalled with nothing held");

endmodule
